FILE: rtl/core/zcbf_pkg.sv
// Shared types and constants for the zero-cross burst-fire modulator.
package zcbf_pkg;

    localparam int unsigned DivW      = 5;
    localparam int unsigned RangeW    = 8;
    localparam int unsigned IntervalW = 8;
    localparam int unsigned TimeW     = 32;
    localparam int unsigned PctW      = 7;
    localparam int unsigned CountW    = 32;
    localparam int unsigned DivCntW   = 4;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 8;

    localparam logic [DivW-1:0]      DIVIDER_RST  = 5'd1;
    localparam logic [DivW-1:0]      DIVIDER_MAX  = 5'd16;
    localparam logic [RangeW-1:0]    RANGE_RST    = 8'd100;
    localparam logic [IntervalW-1:0] INTERVAL_RST = 8'd5;
    localparam logic [PctW-1:0]      PCT_MAX      = 7'd100;

    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_POWER = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DIVIDER      = 2'd0,
        CFG_ACCUM_RANGE  = 2'd1,
        CFG_MIN_INTERVAL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DivW-1:0]      divider;
        logic [RangeW-1:0]    accum_range;
        logic [IntervalW-1:0] min_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic              relay_on;
        logic              edge_accepted;
        logic [CountW-1:0] fired_count;
    } t_result;

endpackage

FILE: rtl/core/zcbf_core.sv
// Modulator state and the per-word edge filter, divider and burst accumulator.
module zcbf_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  logic                      i_command,
    input  logic [zcbf_pkg::TimeW-1:0] i_time_ms,
    input  logic [zcbf_pkg::PctW-1:0]  i_power_percent,
    input  zcbf_pkg::t_cfg            i_cfg,
    output zcbf_pkg::t_result         o_result
);
    import zcbf_pkg::*;

    logic [TimeW-1:0]   r_last_edge, n_last_edge;
    logic [DivCntW-1:0] r_div_cnt, n_div_cnt;
    logic [RangeW-1:0]  r_accum, n_accum;
    logic [PctW-1:0]    r_burst, n_burst;
    logic [CountW-1:0]  r_fire_count, n_fire_count;
    logic               r_relay, n_relay;

    logic [TimeW-1:0]   w_elapsed;
    logic               w_pass;
    logic [DivW-1:0]    w_div_eff;
    logic [DivW-1:0]    w_div_m1_full;
    logic [DivCntW-1:0] w_div_m1;
    logic [RangeW:0]    w_sum;
    logic [RangeW:0]    w_red;
    logic               w_fire;
    logic [PctW-1:0]    w_pct;
    logic               w_accepted;
    logic               w_step;

    assign w_elapsed = i_time_ms - r_last_edge;
    assign w_pass    = (r_last_edge == '0) ||
                       (w_elapsed >= {{(TimeW-IntervalW){1'b0}}, i_cfg.min_interval_ms});

    always_comb begin
        if (i_cfg.divider == '0) begin
            w_div_eff = DIVIDER_RST;
        end else if (i_cfg.divider > DIVIDER_MAX) begin
            w_div_eff = DIVIDER_MAX;
        end else begin
            w_div_eff = i_cfg.divider;
        end
    end
    assign w_div_m1_full = w_div_eff - 5'd1;
    assign w_div_m1      = w_div_m1_full[DivCntW-1:0];

    // wrap test, then clear if still beyond range
    always_comb begin
        w_sum = {1'b0, r_accum} + {2'b00, r_burst};
        if (w_sum >= {1'b0, i_cfg.accum_range}) begin
            w_red  = w_sum - {1'b0, i_cfg.accum_range};
            w_fire = 1'b1;
        end else begin
            w_red  = w_sum;
            w_fire = 1'b0;
        end
        if (w_red > {1'b0, i_cfg.accum_range}) begin
            w_red  = '0;
            w_fire = 1'b1;
        end
    end

    assign w_pct = (i_power_percent > PCT_MAX) ? PCT_MAX : i_power_percent;

    always_comb begin
        n_last_edge  = r_last_edge;
        n_div_cnt    = r_div_cnt;
        n_accum      = r_accum;
        n_burst      = r_burst;
        n_fire_count = r_fire_count;
        n_relay      = r_relay;
        w_accepted   = 1'b0;
        w_step       = 1'b0;
        if (i_item_valid) begin
            if (i_command == CMD_EDGE) begin
                if (w_pass) begin
                    w_accepted  = 1'b1;
                    n_last_edge = i_time_ms;
                    if (r_div_cnt >= w_div_m1) begin
                        w_step       = 1'b1;
                        n_div_cnt    = r_div_cnt - w_div_m1;
                        n_accum      = w_red[RangeW-1:0];
                        n_fire_count = r_fire_count + {{(CountW-1){1'b0}}, w_fire};
                        n_relay      = w_fire;
                    end else begin
                        n_div_cnt = r_div_cnt + 4'd1;
                    end
                end
            end else begin
                n_burst = w_pct;
                if (w_pct == '0) begin
                    n_relay = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge  <= '0;
            r_div_cnt    <= '0;
            r_accum      <= '0;
            r_burst      <= '0;
            r_fire_count <= '0;
            r_relay      <= 1'b0;
        end else begin
            r_last_edge  <= n_last_edge;
            r_div_cnt    <= n_div_cnt;
            r_accum      <= n_accum;
            r_burst      <= n_burst;
            r_fire_count <= n_fire_count;
            r_relay      <= n_relay;
        end
    end

    assign o_result.relay_on      = n_relay;
    assign o_result.edge_accepted = w_accepted;
    assign o_result.fired_count   = n_fire_count;

    // counter never moves by more than one per word
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fire_count == $past(r_fire_count)) ||
                 (r_fire_count == $past(r_fire_count) + 32'd1))
        else $error("fire counter jumped");

    a_accum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_accum <= $past(i_cfg.accum_range))
        else $error("accumulator above range after step");

    a_relay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_relay == (r_fire_count != $past(r_fire_count)))
        else $error("relay level disagrees with fire count");

    a_power_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && (i_command == CMD_POWER) |=> $stable(r_last_edge) &&
                                                     $stable(r_accum))
        else $error("power word disturbed edge state");

endmodule

FILE: rtl/core/zero_cross_burst_fire_modulator_top.sv
// Top level: config registers, input word register, modulator core and result register.
// Each word passes the input word register and then the result register.
// Throughput: one word per cycle while i_out_stall is low; no bubbles between words.
// Input stall is raised only while both registers hold words and the output is stalled.
// Reset is synchronous, active low: clears state, valids and config to defaults.
module zero_cross_burst_fire_modulator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [zcbf_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [zcbf_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [zcbf_pkg::TimeW-1:0]    i_time_ms,
    input  logic [zcbf_pkg::PctW-1:0]     i_power_percent,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_relay_on,
    output logic                          o_edge_accepted,
    output logic [zcbf_pkg::CountW-1:0]   o_fired_count
);
    import zcbf_pkg::*;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic             r_command;
    logic [TimeW-1:0] r_time_ms;
    logic [PctW-1:0]  r_pct;
    logic             r_out_valid;
    t_result          r_result;
    t_result          w_result;
    logic             w_adv;
    logic             w_fire_item;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_fire_item = r_in_valid && w_adv;
    assign o_in_stall  = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.divider         <= DIVIDER_RST;
            r_cfg.accum_range     <= RANGE_RST;
            r_cfg.min_interval_ms <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DIVIDER:      r_cfg.divider         <= i_cfg_data[DivW-1:0];
                CFG_ACCUM_RANGE:  r_cfg.accum_range     <= i_cfg_data[RangeW-1:0];
                CFG_MIN_INTERVAL: r_cfg.min_interval_ms <= i_cfg_data[IntervalW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || w_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && (!r_in_valid || w_adv)) begin
            r_command <= i_command;
            r_time_ms <= i_time_ms;
            r_pct     <= i_power_percent;
        end
    end

    zcbf_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_fire_item),
        .i_command       (r_command),
        .i_time_ms       (r_time_ms),
        .i_power_percent (r_pct),
        .i_cfg           (r_cfg),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_item) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_relay_on      = r_result.relay_on;
    assign o_edge_accepted = r_result.edge_accepted;
    assign o_fired_count   = r_result.fired_count;

endmodule
